// ----- hdl/cip_pkg.sv -----
// Shared widths, types and saturation helper for the complex integer power block.
// Used by the interfaces, cip_div, complex_integer_power and the testbench; no dependencies.
`default_nettype none
package cip_pkg;

	localparam int W = 32;
	localparam int F = 16;
	localparam int E = 32;

	localparam int PW    = 2 * W;
	localparam int NUM_W = W + F;
	localparam int RND_W = PW - F + 1;
	localparam int ACC_W = ((PW - F > NUM_W) ? PW - F : NUM_W) + 2;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [W-1:0]  ONE_MAG = W'(1) << F;
	localparam logic [PW-1:0] HALF    = PW'(1) << (F - 1);

	localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};

	typedef struct packed {
		logic                clamp;
		logic signed [W-1:0] val;
	} sat_t;

	typedef struct packed {
		logic done;
		logic clamp;
	} div_rsp_t;

	function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
		sat_t r;
		if (v > SMAX) begin
			r.clamp = 1'b1;
			r.val   = {1'b0, {(W-1){1'b1}}};
		end else if (v < SMIN) begin
			r.clamp = 1'b1;
			r.val   = {1'b1, {(W-1){1'b0}}};
		end else begin
			r.clamp = 1'b0;
			r.val   = v[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] x);
		return x[W-1] ? W'(-x) : W'(x);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cip_req_if.sv -----
// Request channel: complex base and exponent.
// Depends on cip_pkg.
`default_nettype none
interface cip_req_if;
	logic                        valid;
	logic                        ready;
	logic signed [cip_pkg::W-1:0] base_re;
	logic signed [cip_pkg::W-1:0] base_im;
	logic signed [cip_pkg::E-1:0] exponent;

	modport source (output valid, base_re, base_im, exponent, input ready);
	modport sink   (input valid, base_re, base_im, exponent, output ready);
endinterface
`default_nettype wire

// ----- hdl/cip_rsp_if.sv -----
// Response channel: complex power with status and clamp flag.
// Depends on cip_pkg.
`default_nettype none
interface cip_rsp_if;
	logic                        valid;
	logic                        ready;
	logic signed [cip_pkg::W-1:0] result_re;
	logic signed [cip_pkg::W-1:0] result_im;
	logic                        status;
	logic                        saturated;

	modport source (output valid, result_re, result_im, status, saturated, input ready);
	modport sink   (input valid, result_re, result_im, status, saturated, output ready);
endinterface
`default_nettype wire

// ----- hdl/complex_integer_power.sv -----
// Top level: complex base raised to a signed integer power, Q16.16, saturating.
// Depends on cip_pkg, cip_req_if, cip_rsp_if and cip_div.
//
//  channel | dir | payload                                      | item accepted
//  --------+-----+----------------------------------------------+--------------------
//  req     | in  | base_re, base_im, exponent                   | valid & ready
//  rsp     | out | result_re, result_im, status, saturated      | valid & ready
//
// Each item forms one complex product per set bit of |exponent| and one square per bit below its
// top set bit, on one shared 32x32 multiplier; a nonzero power with a negative exponent adds three
// divider runs and one rounded product. req.ready is high only while the sequencer is idle.
// The finished item sits in the output register, so a new item is taken while rsp is stalled.
// Reset clears the sequencer and the output valid; no memory to clear.
`default_nettype none
module complex_integer_power (
	input wire logic  clk,
	input wire logic  arst_n,
	cip_req_if.sink   req,
	cip_rsp_if.source rsp
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOOP = 8'b0000_0010,
		S_CMUL = 8'b0000_0100,
		S_RDIV = 8'b0000_1000,
		S_RMUL = 8'b0001_0000,
		S_ADIV = 8'b0010_0000,
		S_BDIV = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// working operands
	logic signed [cip_pkg::W-1:0] pr_q, pi_q, br_q, bi_q;
	logic signed [cip_pkg::W-1:0] big_q, small_q, r_q, den_q;
	logic signed [cip_pkg::W-1:0] res_re_q, res_im_q;
	logic [cip_pkg::E-1:0]        m_q;
	logic                         neg_q, mdone_q, tgt_p_q, swap_q, clamp_q, res_st_q;
	logic [2:0]                   k_q;
	logic                         dgo_q;

	// shared multiplier pipeline
	logic [cip_pkg::PW-1:0]        prod_s1;
	logic                          vld_s1, neg_s1, sub_s1, im_s1;
	logic signed [cip_pkg::ACC_W-1:0] acc_re_q, acc_im_q;

	// output register
	logic                         out_v_q;
	logic signed [cip_pkg::W-1:0] out_re_q, out_im_q;
	logic                         out_st_q, out_sat_q;

	// multiplier operand selection
	logic signed [cip_pkg::W-1:0] ar, ai, mx, my;
	logic                         launch;
	logic [cip_pkg::PW:0]         rnd_full;
	logic signed [cip_pkg::ACC_W-1:0] contrib;
	cip_pkg::sat_t                sat_re, sat_im, sat_one;

	// divider
	logic [cip_pkg::W-1:0]        d_nmag;
	logic                         d_nneg;
	logic signed [cip_pkg::W-1:0] d_den, d_q;
	cip_pkg::div_rsp_t            d_rsp;
	logic                         in_acc, swap_now;
	logic [cip_pkg::E-1:0]        e_mag;

	always_comb begin
		ar = tgt_p_q ? pr_q : br_q;
		ai = tgt_p_q ? pi_q : bi_q;
		if (state_q == S_RMUL) begin
			mx = small_q;
			my = r_q;
		end else begin
			mx = (k_q == 3'd0 || k_q == 3'd2) ? ar : ai;
			my = (k_q == 3'd0 || k_q == 3'd3) ? br_q : bi_q;
		end
		launch = ((state_q == S_CMUL) && (k_q < 3'd4)) ||
		         ((state_q == S_RMUL) && (k_q == 3'd0));
	end

	// rounded product, half away from zero, signed back
	always_comb begin
		rnd_full = {1'b0, prod_s1} + {1'b0, cip_pkg::HALF};
		contrib  = {{(cip_pkg::ACC_W-cip_pkg::RND_W){1'b0}},
		            rnd_full[cip_pkg::PW:cip_pkg::F]};
		if (neg_s1 ^ sub_s1)
			contrib = -contrib;
	end

	assign sat_re  = cip_pkg::sat_word(acc_re_q);
	assign sat_im  = cip_pkg::sat_word(acc_im_q);
	assign sat_one = cip_pkg::sat_word(cip_pkg::ACC_W'(cip_pkg::ONE_MAG));
	assign swap_now = cip_pkg::mag_w(pi_q) > cip_pkg::mag_w(pr_q);
	assign e_mag    = req.exponent[cip_pkg::E-1] ? cip_pkg::E'(-req.exponent)
	                                             : cip_pkg::E'(req.exponent);

	// divider operands for the three Smith steps
	always_comb begin
		d_nmag = cip_pkg::mag_w(small_q);
		d_nneg = small_q[cip_pkg::W-1];
		d_den  = big_q;
		unique case (state_q)
			S_ADIV: begin
				d_den  = den_q;
				d_nmag = swap_q ? cip_pkg::mag_w(r_q) : cip_pkg::ONE_MAG;
				d_nneg = swap_q ? r_q[cip_pkg::W-1] : 1'b0;
			end
			S_BDIV: begin
				d_den  = den_q;
				d_nmag = swap_q ? cip_pkg::ONE_MAG : cip_pkg::mag_w(r_q);
				d_nneg = swap_q ? 1'b1 : !r_q[cip_pkg::W-1];
			end
			default: ;
		endcase
	end

	cip_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dgo_q),
		.nmag   (d_nmag),
		.nneg   (d_nneg),
		.d      (d_den),
		.rsp    (d_rsp),
		.q      (d_q)
	);

	assign in_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			dgo_q   <= 1'b0;
			mdone_q <= 1'b0;
			tgt_p_q <= 1'b0;
			vld_s1  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			dgo_q  <= 1'b0;
			vld_s1 <= launch;
			if (rsp.valid && rsp.ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					mdone_q <= 1'b0;
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					k_q <= '0;
					if (m_q == '0) begin
						if (!neg_q || (pr_q == '0 && pi_q == '0)) begin
							state_q <= S_DONE;
						end else begin
							dgo_q   <= 1'b1;
							state_q <= S_RDIV;
						end
					end else if (m_q[0] && !mdone_q) begin
						mdone_q <= 1'b1;
						tgt_p_q <= 1'b1;
						state_q <= S_CMUL;
					end else begin
						mdone_q <= 1'b0;
						if (m_q[cip_pkg::E-1:1] != '0) begin
							tgt_p_q <= 1'b0;
							state_q <= S_CMUL;
						end
					end
				end
				S_CMUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd5)
						state_q <= S_LOOP;
				end
				S_RDIV: if (d_rsp.done) begin
					k_q     <= '0;
					state_q <= S_RMUL;
				end
				S_RMUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd2) begin
						dgo_q   <= 1'b1;
						state_q <= S_ADIV;
					end
				end
				S_ADIV: if (d_rsp.done) begin
					dgo_q   <= 1'b1;
					state_q <= S_BDIV;
				end
				S_BDIV: if (d_rsp.done)
					state_q <= S_DONE;
				S_DONE: if (!out_v_q || rsp.ready) begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1 <= cip_pkg::PW'(cip_pkg::mag_w(mx)) * cip_pkg::PW'(cip_pkg::mag_w(my));
		neg_s1  <= mx[cip_pkg::W-1] ^ my[cip_pkg::W-1];
		sub_s1  <= (state_q == S_CMUL) && (k_q == 3'd1);
		im_s1   <= (state_q == S_CMUL) && (k_q >= 3'd2);

		// accumulators: cleared or preloaded at the start of a product
		if (state_q == S_CMUL && k_q == 3'd0) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (state_q == S_RMUL && k_q == 3'd0) begin
			acc_re_q <= cip_pkg::ACC_W'(big_q);
		end else if (vld_s1) begin
			if (im_s1)
				acc_im_q <= acc_im_q + contrib;
			else
				acc_re_q <= acc_re_q + contrib;
		end

		unique case (state_q)
			S_IDLE: if (in_acc) begin
				br_q    <= req.base_re;
				bi_q    <= req.base_im;
				pr_q    <= sat_one.val;
				pi_q    <= '0;
				m_q     <= e_mag;
				neg_q   <= req.exponent[cip_pkg::E-1];
				clamp_q <= sat_one.clamp;
			end
			S_LOOP: begin
				if (m_q == '0) begin
					res_st_q <= neg_q && pr_q == '0 && pi_q == '0;
					res_re_q <= (neg_q && pr_q == '0 && pi_q == '0) ? '0 : pr_q;
					res_im_q <= (neg_q && pr_q == '0 && pi_q == '0) ? '0 : pi_q;
					swap_q   <= swap_now;
					big_q    <= swap_now ? pi_q : pr_q;
					small_q  <= swap_now ? pr_q : pi_q;
				end else if (!(m_q[0] && !mdone_q)) begin
					m_q <= m_q >> 1;
				end
			end
			S_CMUL: if (k_q == 3'd5) begin
				if (tgt_p_q) begin
					pr_q <= sat_re.val;
					pi_q <= sat_im.val;
				end else begin
					br_q <= sat_re.val;
					bi_q <= sat_im.val;
				end
				clamp_q <= clamp_q | sat_re.clamp | sat_im.clamp;
			end
			S_RDIV: if (d_rsp.done) begin
				r_q     <= d_q;
				clamp_q <= clamp_q | d_rsp.clamp;
			end
			S_RMUL: if (k_q == 3'd2) begin
				den_q   <= sat_re.val;
				clamp_q <= clamp_q | sat_re.clamp;
			end
			S_ADIV: if (d_rsp.done) begin
				res_re_q <= d_q;
				clamp_q  <= clamp_q | d_rsp.clamp;
			end
			S_BDIV: if (d_rsp.done) begin
				res_im_q <= d_q;
				clamp_q  <= clamp_q | d_rsp.clamp;
			end
			S_DONE: if (!out_v_q || rsp.ready) begin
				out_re_q  <= res_re_q;
				out_im_q  <= res_im_q;
				out_st_q  <= res_st_q;
				out_sat_q <= clamp_q;
			end
			default: ;
		endcase
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_v_q;
	assign rsp.result_re = out_re_q;
	assign rsp.result_im = out_im_q;
	assign rsp.status    = out_st_q;
	assign rsp.saturated = out_sat_q;
endmodule
`default_nettype wire

// ----- hdl/cip_div.sv -----
// Restoring divider: (nmag * 2^F) / d, one quotient bit a cycle, rounded and saturated.
// Depends on cip_pkg.
`default_nettype none
module cip_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cip_pkg::W-1:0]       nmag,
	input  wire logic                        nneg,
	input  wire logic signed [cip_pkg::W-1:0] d,
	output cip_pkg::div_rsp_t                rsp,
	output logic signed [cip_pkg::W-1:0]     q
);
	logic                            busy_q, fin_q;
	logic [cip_pkg::CNT_W-1:0]       cnt_q;
	logic [cip_pkg::NUM_W-1:0]       num_q, quo_q;
	logic [cip_pkg::W-1:0]           rem_q, dm_q;
	logic                            neg_q;
	logic [cip_pkg::W:0]             trial;
	logic                            take;
	logic [cip_pkg::NUM_W:0]         qr;
	logic signed [cip_pkg::ACC_W-1:0] qs;
	cip_pkg::sat_t                   sr;

	assign trial = {rem_q, num_q[cip_pkg::NUM_W-1]};
	assign take  = trial >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= cip_pkg::CNT_W'(cip_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - cip_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {nmag, {cip_pkg::F{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			dm_q  <= cip_pkg::mag_w(d);
			neg_q <= nneg ^ d[cip_pkg::W-1];
		end else if (busy_q) begin
			num_q <= {num_q[cip_pkg::NUM_W-2:0], 1'b0};
			rem_q <= take ? cip_pkg::W'(trial - {1'b0, dm_q}) : trial[cip_pkg::W-1:0];
			quo_q <= {quo_q[cip_pkg::NUM_W-2:0], take};
		end
	end

	// round half away from zero on the remainder
	always_comb begin
		qr = {1'b0, quo_q} + ((rem_q >= dm_q - rem_q) ? (cip_pkg::NUM_W+1)'(1)
		                                              : (cip_pkg::NUM_W+1)'(0));
		qs = {{(cip_pkg::ACC_W-cip_pkg::NUM_W-1){1'b0}}, qr};
		if (neg_q)
			qs = -qs;
		sr = cip_pkg::sat_word(qs);
	end

	assign rsp.done  = fin_q;
	assign rsp.clamp = (dm_q != '0) && sr.clamp;
	assign q         = (dm_q == '0) ? '0 : sr.val;
endmodule
`default_nettype wire

// ----- sim/tb_complex_integer_power.sv -----
// Testbench for complex_integer_power: directed table, then shaped random items.
// Depends on cip_pkg, cip_req_if, cip_rsp_if and the block itself.
`default_nettype none
module tb_complex_integer_power;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = cip_pkg::W;
	localparam int F = cip_pkg::F;
	localparam int E = cip_pkg::E;

	localparam int RAND_ITEMS  = 1530;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYC   = 700;   // longer than the slowest item
	localparam int HOLD_CYC    = 3000;  // long receiver hold-off
	localparam int HOLD_AT     = 300;   // items sent before the hold-off begins
	localparam int PAUSE_AT    = 800;   // sender drains the pipe here

	localparam logic signed [W-1:0] ONE_Q  = 32'sh0001_0000;
	localparam logic signed [W-1:0] WMAX   = 32'sh7fff_ffff;
	localparam logic signed [W-1:0] WMIN   = 32'sh8000_0000;
	localparam logic signed [E-1:0] EMAX   = 32'sh7fff_ffff;
	localparam logic signed [E-1:0] EMIN   = 32'sh8000_0000;

	localparam bit ST_OK     = 1'b0;
	localparam bit ST_DOMAIN = 1'b1;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		logic                status;
		logic                saturated;
	} power_t;

	typedef struct {
		logic signed [W-1:0] base_re;
		logic signed [W-1:0] base_im;
		logic signed [E-1:0] exponent;
		bit                  typed;   // expected result written in the row
		power_t              res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	cip_req_if req_ch();
	cip_rsp_if rsp_ch();

	complex_integer_power u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	power_t pending_powers[$];
	int     fail_cnt   = 0;
	int     items_sent = 0;
	longint cycle_cnt  = 0;
	bit     clip_seen;

	// ---------------------------------------------------------------------
	// Clock and cycle limit
	// ---------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Predictor: square-and-multiply in Q16.16, saturating every step,
	// Smith's division for the reciprocal.
	// ---------------------------------------------------------------------
	function automatic wide_t abs_w(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// clamp to the word range; note any clamp for this item
	function automatic wide_t clip_word(wide_t v);
		if (v > wide_t'(WMAX)) begin
			clip_seen = 1'b1;
			return wide_t'(WMAX);
		end else if (v < wide_t'(WMIN)) begin
			clip_seen = 1'b1;
			return wide_t'(WMIN);
		end
		return v;
	endfunction

	// product rounded half away from zero, kept wide
	function automatic wide_t round_prod(wide_t x, wide_t y);
		wide_t m;
		m = (abs_w(x) * abs_w(y) + (wide_t'(1) <<< (F - 1))) >>> F;
		return ((x < 0) != (y < 0)) ? -m : m;
	endfunction

	// (sign, magnitude) numerator over d, rounded half away, clamped
	function automatic wide_t fix_quot(wide_t nmag, bit nneg, wide_t d);
		wide_t dm, num, q, r;
		if (d == 0)
			return 0;
		dm  = abs_w(d);
		num = nmag <<< F;
		q   = num / dm;
		r   = num % dm;
		if (r >= dm - r)
			q = q + 1;
		return clip_word((nneg != (d < 0)) ? -q : q);
	endfunction

	function automatic power_t predict_power(logic signed [W-1:0] b_re,
	                                         logic signed [W-1:0] b_im,
	                                         logic signed [E-1:0] ex);
		wide_t  br, bi, pr, pi, nr, ni, rat, den, one_w, mag_e;
		power_t p;
		clip_seen = 1'b0;
		br    = b_re;
		bi    = b_im;
		one_w = wide_t'(1) <<< F;
		pr    = clip_word(one_w);
		pi    = 0;
		mag_e = abs_w(wide_t'(ex));
		while (mag_e != 0) begin
			if (mag_e[0]) begin
				nr = clip_word(round_prod(pr, br) - round_prod(pi, bi));
				ni = clip_word(round_prod(pr, bi) + round_prod(pi, br));
				pr = nr;
				pi = ni;
			end
			mag_e = mag_e >>> 1;
			// the square after the last exponent bit is never formed
			if (mag_e != 0) begin
				nr = clip_word(round_prod(br, br) - round_prod(bi, bi));
				ni = clip_word(round_prod(br, bi) + round_prod(bi, br));
				br = nr;
				bi = ni;
			end
		end
		p.status = ST_OK;
		if (ex < 0) begin
			if (pr == 0 && pi == 0) begin
				// zero power cannot be inverted, whether base was zero or underflowed
				p.status = ST_DOMAIN;
				pr = 0;
				pi = 0;
			end else if (abs_w(pr) >= abs_w(pi)) begin
				rat = fix_quot(abs_w(pi), pi < 0, pr);
				den = clip_word(pr + round_prod(pi, rat));
				pr  = fix_quot(one_w, 1'b0, den);
				pi  = fix_quot(abs_w(rat), !(rat < 0), den);
			end else begin
				rat = fix_quot(abs_w(pr), pr < 0, pi);
				den = clip_word(round_prod(pr, rat) + pi);
				pr  = fix_quot(abs_w(rat), rat < 0, den);
				pi  = fix_quot(one_w, 1'b1, den);
			end
		end
		p.re        = pr[W-1:0];
		p.im        = pi[W-1:0];
		p.saturated = clip_seen;
		return p;
	endfunction

	// ---------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		else if (sel < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// offer one item, wait for the handshake, file its expected result
	task automatic send_item(logic signed [W-1:0] b_re, logic signed [W-1:0] b_im,
	                         logic signed [E-1:0] ex, bit typed, power_t typed_res);
		req_ch.valid    <= 1'b1;
		req_ch.base_re  <= b_re;
		req_ch.base_im  <= b_im;
		req_ch.exponent <= ex;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		pending_powers.push_back(typed ? typed_res : predict_power(b_re, b_im, ex));
		items_sent++;
	endtask

	task automatic idle_sender();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// near-unit parts keep powers in range; small ones underflow; kind 3 is zero or up to one half; kind 0 is raw
	function automatic logic signed [W-1:0] pick_part(int kind);
		logic signed [W-1:0] v;
		case (kind)
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(32'h0000_c000, 32'h0001_4000);
				if ($urandom_range(0, 1)) v = -v;
			end
			2: begin
				v = $urandom_range(0, 32'h0000_2000);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: begin
				v = $urandom_range(0, 3) == 0 ? 32'sd0 : $urandom_range(0, 32'h0000_8000);
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [E-1:0] pick_exponent();
		int sel;
		logic signed [E-1:0] ex;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			ex = $urandom_range(1, 12);
			if ($urandom_range(0, 1)) ex = -ex;
		end else if (sel < 78) begin
			ex = 0;
		end else if (sel < 95) begin
			ex = $urandom;
		end else begin
			ex = $urandom_range(0, 1) ? EMAX : EMIN;
		end
		return ex;
	endfunction

	initial begin
		dir_row_t dir_rows[16];
		power_t   no_res;
		power_t   one_ok;
		power_t   zero_ok;
		power_t   zero_err;
		int       kind;

		no_res   = '{re: 0, im: 0, status: ST_OK, saturated: 1'b0};
		one_ok   = '{re: ONE_Q, im: 0, status: ST_OK, saturated: 1'b0};
		zero_ok  = '{re: 0, im: 0, status: ST_OK, saturated: 1'b0};
		zero_err = '{re: 0, im: 0, status: ST_DOMAIN, saturated: 1'b0};

		// exponent zero gives one; zero base gives zero or a domain error;
		// unit base stays one, whatever the exponent
		dir_rows = '{
			'{0,        0,        0,      1, one_ok},
			'{WMAX,     WMIN,     0,      1, one_ok},
			'{0,        0,        5,      1, zero_ok},
			'{0,        0,        EMAX,   1, zero_ok},
			'{0,        0,        -1,     1, zero_err},
			'{0,        0,        EMIN,   1, zero_err},
			'{ONE_Q,    0,        7,      1, one_ok},
			'{ONE_Q,    0,        -1,     1, one_ok},
			'{ONE_Q,    0,        EMIN,   1, one_ok},
			'{ONE_Q,    0,        EMAX,   1, one_ok},
			'{WMAX,     WMAX,     2,      0, no_res},   // the square clamps
			'{WMIN,     WMIN,     -3,     0, no_res},
			'{1,        0,        -3,     0, no_res},   // underflow, then domain error
			'{32'sh100, 32'sh300, -2,     0, no_res},   // larger imaginary part
			'{32'sh18000, -32'sh8000, -5, 0, no_res},
			'{0,        -ONE_Q,   EMIN,   0, no_res}
		};

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.base_re  = '0;
		req_ch.base_im  = '0;
		req_ch.exponent = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].base_re, dir_rows[i].base_im, dir_rows[i].exponent,
			          dir_rows[i].typed, dir_rows[i].res);
			idle_sender();
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (items_sent == PAUSE_AT) begin
				// let the whole pipe drain before carrying on
				req_ch.valid <= 1'b0;
				while (pending_powers.size() != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 9);
			kind = kind < 2 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3;
			send_item(pick_part(kind), pick_part(kind), pick_exponent(), 1'b0, no_res);
			if ($urandom_range(0, 3) != 0 || n >= 900)
				idle_sender();
		end
		req_ch.valid <= 1'b0;

		while (pending_powers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (fail_cnt == 0 && pending_powers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Receiver: random stalls, one long hold-off while the sender keeps going
	// ---------------------------------------------------------------------
	initial begin
		int  hold_left;
		bit  hold_done;
		int  stall_left;
		int  sel;
		hold_left    = 0;
		hold_done    = 1'b0;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				sel = $urandom_range(0, 99);
				// quiet stretch in the middle of the run: never stall
				if (items_sent > 1100 && items_sent < 1300)
					stall_left = 0;
				else if (sel < 25)
					stall_left = $urandom_range(1, 4);
				else if (sel < 28)
					stall_left = $urandom_range(20, 100);
				rsp_ch.ready <= (stall_left == 0);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		power_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_powers.size() == 0) begin
				$error("result with no item outstanding: re %0d im %0d",
				       rsp_ch.result_re, rsp_ch.result_im);
				fail_cnt++;
			end else begin
				want = pending_powers.pop_front();
				if (rsp_ch.result_re !== want.re) begin
					$error("result_re: expected %0d, got %0d", want.re, rsp_ch.result_re);
					fail_cnt++;
				end
				if (rsp_ch.result_im !== want.im) begin
					$error("result_im: expected %0d, got %0d", want.im, rsp_ch.result_im);
					fail_cnt++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_cnt++;
				end
				if (rsp_ch.saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d",
					       want.saturated, rsp_ch.saturated);
					fail_cnt++;
				end
			end
		end
	end

endmodule
`default_nettype wire
